// File: hdl/tts_pkg.sv
package tts_pkg;

	// request command codes
	typedef enum logic [1:0] {
		CMD_SHADE    = 2'd0,
		CMD_LOAD_TEX = 2'd1,
		CMD_LOAD_PAL = 2'd2
	} cmd_t;

	// brightness modifier fix-up
	localparam logic [7:0] MOD_THRESH = 8'd128;
	localparam logic [7:0] MOD_SUBST  = 8'd196;

	// request fields carried alongside the coordinate divider:
	// cmd, table_index, table_value, palette index, palette out of range
	localparam int SIDE_W = 2 + 8 + 24 + 4 + 1;

	// load strobes for the shading stages
	typedef struct packed {
		logic ld_prod;
		logic ld_out;
	} shd_ctrl_t;

endpackage

// File: hdl/tts_ram.sv
module tts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/tts_coord.sv
module tts_coord #(
	parameter int TEX_SIZE = 16,
	parameter int SW       = 1
) (
	input  logic                                       clk,
	// ld[0] captures the request, ld[j] loads divider stage j
	input  logic [(TEX_SIZE > 1 ? $clog2(TEX_SIZE) : 1):0] ld,
	input  logic [7:0]                                 col_offset,
	input  logic [7:0]                                 row_offset,
	input  logic [8:0]                                 tile_width,
	input  logic [8:0]                                 tile_height,
	input  logic [SW-1:0]                              side_in,
	output logic [(TEX_SIZE > 1 ? $clog2(TEX_SIZE) : 1)-1:0] tex_col,
	output logic [(TEX_SIZE > 1 ? $clog2(TEX_SIZE) : 1)-1:0] tex_row,
	output logic [SW-1:0]                              side_out
);

	localparam int QB = (TEX_SIZE > 1) ? $clog2(TEX_SIZE) : 1;
	localparam int CW = 9 + QB;

	// axis 0 is the column, axis 1 the row
	logic [CW-1:0] rem_s  [2][QB+1];
	logic [8:0]    size_s [2][QB+1];
	logic [QB-1:0] quo_s  [2][QB+1];
	logic          zero_s [2][QB+1];
	logic          over_s [2][QB+1];
	logic [SW-1:0] side_s [QB+1];

	logic [CW-1:0] sub  [2][QB];
	logic          take [2][QB];

	logic [7:0] off_in  [2];
	logic [8:0] size_in [2];

	assign off_in[0]  = col_offset;
	assign off_in[1]  = row_offset;
	assign size_in[0] = tile_width;
	assign size_in[1] = tile_height;

	// restoring division, one quotient bit per stage, msb first
	always_comb begin
		for (int j = 0; j < QB; j++) begin
			for (int a = 0; a < 2; a++) begin
				sub[a][j]  = CW'(size_s[a][j]) << (QB - 1 - j);
				take[a][j] = (rem_s[a][j] >= sub[a][j]);
			end
		end
	end

	// capture: numerator TEX_SIZE*offset, special-case flags
	// then one quotient bit per stage
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			for (int a = 0; a < 2; a++) begin
				rem_s[a][0]  <= CW'(TEX_SIZE) * CW'(off_in[a]);
				size_s[a][0] <= size_in[a];
				quo_s[a][0]  <= '0;
				zero_s[a][0] <= (size_in[a] == 9'd0);
				over_s[a][0] <= ({1'b0, off_in[a]} >= size_in[a]);
			end
			side_s[0] <= side_in;
		end
		for (int j = 0; j < QB; j++) begin
			if (ld[j+1]) begin
				for (int a = 0; a < 2; a++) begin
					rem_s[a][j+1]  <= take[a][j] ? (rem_s[a][j] - sub[a][j]) : rem_s[a][j];
					quo_s[a][j+1]  <= quo_s[a][j]
						| (take[a][j] ? (QB'(1) << (QB - 1 - j)) : '0);
					size_s[a][j+1] <= size_s[a][j];
					zero_s[a][j+1] <= zero_s[a][j];
					over_s[a][j+1] <= over_s[a][j];
				end
				side_s[j+1] <= side_s[j];
			end
		end
	end

	logic [QB-1:0] q_fin [2];

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			if (zero_s[a][QB]) begin
				q_fin[a] = '0;
			end else if (over_s[a][QB]) begin
				q_fin[a] = QB'(TEX_SIZE - 1);
			end else begin
				q_fin[a] = quo_s[a][QB];
			end
		end
	end

	assign tex_col  = q_fin[0];
	assign tex_row  = q_fin[1];
	assign side_out = side_s[QB];

endmodule

// File: hdl/tts_shade.sv
module tts_shade (
	input  logic               clk,
	input  tts_pkg::shd_ctrl_t ctrl,
	input  logic [7:0]         tex_mod,
	input  logic [23:0]        pal_color,
	input  logic               pal_zero,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);

	logic [7:0]  modf;
	logic [23:0] color;
	logic [15:0] prod_sp [3];
	logic [16:0] sum     [3];
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;

	always_comb begin
		modf  = (tex_mod < tts_pkg::MOD_THRESH) ? tts_pkg::MOD_SUBST : tex_mod;
		color = pal_zero ? 24'd0 : pal_color;
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_prod) begin
			prod_sp[0] <= 16'(color[23:16]) * 16'(modf);
			prod_sp[1] <= 16'(color[15:8]) * 16'(modf);
			prod_sp[2] <= 16'(color[7:0]) * 16'(modf);
		end
	end

	// floor(p/255) as (p + (p>>8) + 1) >> 8, exact for products of two 8-bit values
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = 17'(prod_sp[c]) + 17'(prod_sp[c][15:8]) + 17'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_out) begin
			red_q   <= sum[0][15:8];
			green_q <= sum[1][15:8];
			blue_q  <= sum[2][15:8];
		end
	end

	assign red   = red_q;
	assign green = green_q;
	assign blue  = blue_q;

endmodule

// File: hdl/textured_tile_pixel_shader_unit.sv
// stages: request capture, coordinate divider (one quotient bit per stage),
// store access, channel products, output register; loads and shades mix freely
// throughput: one request per cycle unless out_ready stalls the output
// reset: asynchronous, clears the stage valid bits only
// texture and palette stores are not cleared and read undefined until loaded
module textured_tile_pixel_shader_unit #(
	parameter int TEX_SIZE      = 16,
	parameter int PALETTE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  table_index,
	input  logic [23:0] table_value,
	input  logic [7:0]  col_offset,
	input  logic [7:0]  row_offset,
	input  logic [8:0]  tile_width,
	input  logic [8:0]  tile_height,
	input  logic [3:0]  outline_color,
	input  logic [3:0]  fill_color,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);

	// quotient bits per axis, stage numbering
	localparam int QB  = (TEX_SIZE > 1) ? $clog2(TEX_SIZE) : 1;
	localparam int DS  = QB + 1;      // coordinates ready, stores accessed here
	localparam int NS  = QB + 4;      // output register
	localparam int TEX_ENTRIES = TEX_SIZE * TEX_SIZE;
	localparam int TAW = (TEX_ENTRIES > 1) ? $clog2(TEX_ENTRIES) : 1;
	localparam int PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int SW  = tts_pkg::SIDE_W;

	// stage valid bits, ready chain, stage loads
	logic [NS:1]   v_q;
	logic [NS+1:1] rdy;
	logic [NS:1]   vsrc;
	logic [NS:1]   ld;

	// request side fields
	logic [3:0]    pal_idx;
	logic          pal_oor;
	logic [SW-1:0] side_in;
	logic [SW-1:0] side_ds;

	// fields at the store access stage
	logic [1:0]    cmd_ds;
	logic [7:0]    tidx_ds;
	logic [23:0]   tval_ds;
	logic [3:0]    pidx_ds;
	logic          poor_ds;
	logic [QB-1:0] tex_col;
	logic [QB-1:0] tex_row;
	logic          shade_ds;

	// store ports
	logic           tex_we;
	logic           pal_we;
	logic           rd_en;
	logic [TAW-1:0] tex_raddr;
	logic [7:0]     tex_rdata;
	logic [23:0]    pal_rdata;

	// palette out-of-range flag lines up with the store read data
	logic pal_zero_sr;

	tts_pkg::shd_ctrl_t shd_ctrl;

	// outline on first row or column, fill elsewhere
	always_comb begin
		pal_idx = ((col_offset == 8'd0) || (row_offset == 8'd0)) ? outline_color : fill_color;
		pal_oor = (32'(pal_idx) >= PALETTE_DEPTH);
		side_in = {cmd, table_index, table_value, pal_idx, pal_oor};
	end

	assign {cmd_ds, tidx_ds, tval_ds, pidx_ds, poor_ds} = side_ds;
	assign shade_ds = (cmd_ds == tts_pkg::CMD_SHADE);

	// a stage takes new data when empty or when its content moves on
	always_comb begin
		rdy[NS+1] = out_ready;
		for (int k = NS; k >= 1; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end

	// loads and unused codes end at the store stage, only shades go further
	always_comb begin
		vsrc[1] = in_valid;
		for (int k = 2; k <= NS; k++) begin
			vsrc[k] = v_q[k-1];
		end
		vsrc[DS+1] = v_q[DS] && shade_ds;
		ld = vsrc & rdy[NS:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (rdy[k]) begin
					v_q[k] <= vsrc[k];
				end
			end
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = v_q[NS];

	// texture coordinate divider, both axes in lockstep
	tts_coord #(
		.TEX_SIZE (TEX_SIZE),
		.SW       (SW)
	) u_coord (
		.clk         (clk),
		.ld          (ld[DS:1]),
		.col_offset  (col_offset),
		.row_offset  (row_offset),
		.tile_width  (tile_width),
		.tile_height (tile_height),
		.side_in     (side_in),
		.tex_col     (tex_col),
		.tex_row     (tex_row),
		.side_out    (side_ds)
	);

	// all store reads and writes happen at one stage, in request order,
	// so a load always lands before any later shade reads the entry
	always_comb begin
		tex_we = v_q[DS] && rdy[DS+1] && (cmd_ds == tts_pkg::CMD_LOAD_TEX)
			&& (32'(tidx_ds) < TEX_ENTRIES);
		pal_we = v_q[DS] && rdy[DS+1] && (cmd_ds == tts_pkg::CMD_LOAD_PAL)
			&& (32'(tidx_ds) < PALETTE_DEPTH);
		rd_en  = ld[DS+1];
		tex_raddr = TAW'(TAW'(tex_row) * TAW'(TEX_SIZE)) + TAW'(tex_col);
	end

	tts_ram #(
		.WIDTH (8),
		.DEPTH (TEX_ENTRIES)
	) u_tex_ram (
		.clk   (clk),
		.we    (tex_we),
		.waddr (TAW'(tidx_ds)),
		.wdata (tval_ds[7:0]),
		.re    (rd_en),
		.raddr (tex_raddr),
		.rdata (tex_rdata)
	);

	tts_ram #(
		.WIDTH (24),
		.DEPTH (PALETTE_DEPTH)
	) u_pal_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (PAW'(tidx_ds)),
		.wdata (tval_ds),
		.re    (rd_en),
		.raddr (PAW'(pidx_ds)),
		.rdata (pal_rdata)
	);

	always_ff @(posedge clk) begin
		if (ld[DS+1]) begin
			pal_zero_sr <= poor_ds;
		end
	end

	// modifier fix-up, channel scaling and output register
	assign shd_ctrl.ld_prod = ld[DS+2];
	assign shd_ctrl.ld_out  = ld[NS];

	tts_shade u_shade (
		.clk       (clk),
		.ctrl      (shd_ctrl),
		.tex_mod   (tex_rdata),
		.pal_color (pal_rdata),
		.pal_zero  (pal_zero_sr),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule
